>>> design/ptt_pkg.sv
package ptt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ID_MODULUS  = 1000;
    localparam int QUEUE_DEPTH = 2;

    localparam int COORD_W   = 13;
    localparam int CENTRE_W  = COORD_W + 1;
    localparam int FRAME_W   = 32;
    localparam int ID_W      = 10;
    localparam int CFG_W     = 8;
    localparam int REMOVED_W = 5;
    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_BOX   = 1'b0;
    localparam logic OP_PURGE = 1'b1;

    localparam logic CFG_KEEP_LIMIT   = 1'b0;
    localparam logic CFG_MATCH_RADIUS = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] keep_limit;
        logic [CFG_W-1:0] match_radius;
    } t_cfg;

    typedef struct packed {
        logic                       op;
        logic signed [CENTRE_W-1:0] cx;
        logic signed [CENTRE_W-1:0] cy;
        logic [FRAME_W-1:0]         frame;
    } t_item;

    typedef struct packed {
        logic signed [CENTRE_W-1:0] cx;
        logic signed [CENTRE_W-1:0] cy;
        logic [FRAME_W-1:0]         frame;
        logic [ID_W-1:0]            id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> design/ptt_ram.sv
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ptt_front.sv
module ptt_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_left,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_top,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_right,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_bottom,
    input  logic [ptt_pkg::FRAME_W-1:0]         i_frame_number,
    output logic                                o_q_valid,
    output ptt_pkg::t_item                      o_q_item,
    input  logic                                i_q_pop
);

    ptt_pkg::t_item              r_queue [ptt_pkg::QUEUE_DEPTH];
    logic [ptt_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [ptt_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [ptt_pkg::QCNT_W-1:0]  r_count;
    ptt_pkg::t_item              in_item;
    logic                        push;
    logic                        pop;

    always_comb begin
        in_item.op    = i_op;
        in_item.cx    = ptt_pkg::CENTRE_W'(i_box_left) + ptt_pkg::CENTRE_W'(i_box_right);
        in_item.cy    = ptt_pkg::CENTRE_W'(i_box_top) + ptt_pkg::CENTRE_W'(i_box_bottom);
        in_item.frame = i_frame_number;
    end

    assign busy      = (r_count == ptt_pkg::QCNT_W'(ptt_pkg::QUEUE_DEPTH));
    assign push      = start && !busy;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_queue[r_wr_ptr] <= in_item;
                r_wr_ptr <= (r_wr_ptr == ptt_pkg::QPTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == ptt_pkg::QPTR_W'(ptt_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/ptt_back.sv
module ptt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptt_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_valid,
    input  ptt_pkg::t_item                  i_q_item,
    output logic                            o_q_pop,
    output logic                            o_strobe,
    output logic [ptt_pkg::ID_W-1:0]        o_track_id,
    output logic                            o_is_new,
    output logic                            o_table_full,
    output logic [ptt_pkg::REMOVED_W-1:0]   o_removed_count
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                        r_state, n_state;
    ptt_pkg::t_item                r_item, n_item;
    logic [ptt_pkg::CNT_W-1:0]     r_fill, n_fill;
    logic [ptt_pkg::CNT_W-1:0]     r_rd_idx, n_rd_idx;
    logic [ptt_pkg::CNT_W-1:0]     r_chk_idx, n_chk_idx;
    logic                          r_chk_valid, n_chk_valid;
    logic [ptt_pkg::CNT_W-1:0]     r_keep, n_keep;
    logic [ptt_pkg::CNT_W-1:0]     r_removed, n_removed;
    logic [ptt_pkg::ID_W-1:0]      r_next_id, n_next_id;
    logic                          r_strobe, n_strobe;
    logic [ptt_pkg::ID_W-1:0]      r_track_id, n_track_id;
    logic                          r_is_new, n_is_new;
    logic                          r_table_full, n_table_full;
    logic [ptt_pkg::REMOVED_W-1:0] r_removed_count, n_removed_count;

    logic                          ram_we;
    logic [ptt_pkg::IDX_W-1:0]     ram_waddr;
    ptt_pkg::t_entry               ram_wdata;
    logic [ptt_pkg::ENTRY_W-1:0]   ram_rdata;
    ptt_pkg::t_entry               cur;

    logic signed [ptt_pkg::CENTRE_W+1:0] dx, dy, lim;
    logic [ptt_pkg::FRAME_W:0]           age_sum;
    logic                                live;
    logic                                close;
    logic                                last;
    logic [ptt_pkg::ID_W:0]              id_inc;

    ptt_ram #(
        .WIDTH (ptt_pkg::ENTRY_W),
        .DEPTH (ptt_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx[ptt_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign cur     = ptt_pkg::t_entry'(ram_rdata);
    assign dx      = (ptt_pkg::CENTRE_W+2)'(cur.cx) - (ptt_pkg::CENTRE_W+2)'(r_item.cx);
    assign dy      = (ptt_pkg::CENTRE_W+2)'(cur.cy) - (ptt_pkg::CENTRE_W+2)'(r_item.cy);
    assign lim     = $signed({{(ptt_pkg::CENTRE_W+1-ptt_pkg::CFG_W){1'b0}},
                              i_cfg.match_radius, 1'b0});
    assign close   = (dx < lim) && (dx > -lim) && (dy < lim) && (dy > -lim);
    assign age_sum = {1'b0, cur.frame} + (ptt_pkg::FRAME_W+1)'(i_cfg.keep_limit);
    assign live    = (age_sum >= {1'b0, r_item.frame});
    assign last    = ((r_chk_idx + 1'b1) == r_fill);
    assign id_inc  = {1'b0, r_next_id} + 1'b1;

    always_comb begin
        n_state         = r_state;
        n_item          = r_item;
        n_fill          = r_fill;
        n_rd_idx        = r_rd_idx;
        n_chk_idx       = r_chk_idx;
        n_chk_valid     = 1'b0;
        n_keep          = r_keep;
        n_removed       = r_removed;
        n_next_id       = r_next_id;
        n_strobe        = 1'b0;
        n_track_id      = r_track_id;
        n_is_new        = r_is_new;
        n_table_full    = r_table_full;
        n_removed_count = r_removed_count;
        o_q_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r_fill[ptt_pkg::IDX_W-1:0];
        ram_wdata.cx    = r_item.cx;
        ram_wdata.cy    = r_item.cy;
        ram_wdata.frame = r_item.frame;
        ram_wdata.id    = r_next_id;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_item    = i_q_item;
                    n_rd_idx  = '0;
                    n_keep    = '0;
                    n_removed = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_idx < r_fill) begin
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_rd_idx;
                    n_rd_idx    = r_rd_idx + 1'b1;
                end
                if (r_item.op == ptt_pkg::OP_PURGE) begin
                    if (r_fill == '0 || (r_chk_valid && last)) begin
                        n_keep    = r_keep;
                        n_removed = r_removed;
                        if (r_chk_valid) begin
                            if (live) begin
                                n_keep = r_keep + 1'b1;
                            end else begin
                                n_removed = r_removed + 1'b1;
                            end
                        end
                        n_fill          = n_keep;
                        n_strobe        = 1'b1;
                        n_track_id      = '0;
                        n_is_new        = 1'b0;
                        n_table_full    = 1'b0;
                        n_removed_count = ptt_pkg::REMOVED_W'(n_removed);
                        n_state         = S_IDLE;
                    end else if (r_chk_valid) begin
                        if (live) begin
                            n_keep = r_keep + 1'b1;
                        end else begin
                            n_removed = r_removed + 1'b1;
                        end
                    end
                    if (r_chk_valid && live) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_keep[ptt_pkg::IDX_W-1:0];
                        ram_wdata    = cur;
                    end
                end else begin
                    if (r_chk_valid && close && live) begin
                        ram_we          = 1'b1;
                        ram_waddr       = r_chk_idx[ptt_pkg::IDX_W-1:0];
                        ram_wdata.id    = cur.id;
                        n_strobe        = 1'b1;
                        n_track_id      = cur.id;
                        n_is_new        = 1'b0;
                        n_table_full    = 1'b0;
                        n_removed_count = '0;
                        n_state         = S_IDLE;
                    end else if (r_fill == '0 || (r_chk_valid && last)) begin
                        n_next_id = (id_inc == (ptt_pkg::ID_W+1)'(ptt_pkg::ID_MODULUS)) ?
                                    '0 : id_inc[ptt_pkg::ID_W-1:0];
                        if (r_fill < ptt_pkg::CNT_W'(ptt_pkg::TABLE_DEPTH)) begin
                            ram_we       = 1'b1;
                            n_fill       = r_fill + 1'b1;
                            n_table_full = 1'b0;
                        end else begin
                            n_table_full = 1'b1;
                        end
                        n_strobe        = 1'b1;
                        n_track_id      = r_next_id;
                        n_is_new        = 1'b1;
                        n_removed_count = '0;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_next_id   <= '0;
            r_chk_valid <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_item          <= n_item;
            r_fill          <= n_fill;
            r_rd_idx        <= n_rd_idx;
            r_chk_idx       <= n_chk_idx;
            r_chk_valid     <= n_chk_valid;
            r_keep          <= n_keep;
            r_removed       <= n_removed;
            r_next_id       <= n_next_id;
            r_strobe        <= n_strobe;
            r_track_id      <= n_track_id;
            r_is_new        <= n_is_new;
            r_table_full    <= n_table_full;
            r_removed_count <= n_removed_count;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_track_id      = r_track_id;
    assign o_is_new        = r_is_new;
    assign o_table_full    = r_table_full;
    assign o_removed_count = r_removed_count;

endmodule

>>> design/proximity_track_table.sv
// Track association table for detection boxes. An item is taken when start is
// high and busy is low; busy rises only while the two-beat input queue is full.
// Each item yields one result, shown on the result ports for a single cycle with
// o_strobe high; the receiver cannot stall, so sample it then. Box and purge
// items scan the stored entries through a single-read-port table memory, one entry
// per cycle: all stored entries (0 to 16) unless a box item matches an earlier one.
// The back end takes a new item from the queue only once it is done with the last
// one. Write configuration only while the block is idle.
module proximity_track_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_left,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_top,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_right,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_bottom,
    input  logic [ptt_pkg::FRAME_W-1:0]         i_frame_number,
    output logic                                o_strobe,
    output logic [ptt_pkg::ID_W-1:0]            o_track_id,
    output logic                                o_is_new,
    output logic                                o_table_full,
    output logic [ptt_pkg::REMOVED_W-1:0]       o_removed_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]           i_cfg_data
);

    ptt_pkg::t_cfg  r_cfg;
    ptt_pkg::t_item q_item;
    logic           q_valid;
    logic           q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_limit   <= ptt_pkg::CFG_W'(10);
            r_cfg.match_radius <= ptt_pkg::CFG_W'(10);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ptt_pkg::CFG_KEEP_LIMIT:   r_cfg.keep_limit   <= i_cfg_data;
                ptt_pkg::CFG_MATCH_RADIUS: r_cfg.match_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ptt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_box_left     (i_box_left),
        .i_box_top      (i_box_top),
        .i_box_right    (i_box_right),
        .i_box_bottom   (i_box_bottom),
        .i_frame_number (i_frame_number),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    ptt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_q_pop         (q_pop),
        .o_strobe        (o_strobe),
        .o_track_id      (o_track_id),
        .o_is_new        (o_is_new),
        .o_table_full    (o_table_full),
        .o_removed_count (o_removed_count)
    );

endmodule

>>> bench/ptt_checker.sv
`timescale 1ns / 100ps

module ptt_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                i_op,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_left,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_top,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_right,
    input  logic signed [ptt_pkg::COORD_W-1:0]  i_box_bottom,
    input  logic [ptt_pkg::FRAME_W-1:0]         i_frame_number,
    input  logic                                o_strobe,
    input  logic [ptt_pkg::ID_W-1:0]            o_track_id,
    input  logic                                o_is_new,
    input  logic                                o_table_full,
    input  logic [ptt_pkg::REMOVED_W-1:0]       o_removed_count,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [ptt_pkg::CFG_W-1:0]           i_cfg_data,
    output int                                  fail_count,
    output int                                  results_due
);
    import ptt_pkg::*;

    typedef logic [FRAME_W:0] age_t;

    typedef struct packed {
        logic [ID_W-1:0]      track_id;
        logic                 is_new;
        logic                 table_full;
        logic [REMOVED_W-1:0] removed_count;
    } track_result_t;

    logic                       slot_live [TABLE_DEPTH];
    logic signed [CENTRE_W-1:0] slot_cx   [TABLE_DEPTH];
    logic signed [CENTRE_W-1:0] slot_cy   [TABLE_DEPTH];
    logic [FRAME_W-1:0]         slot_seen [TABLE_DEPTH];
    logic [ID_W-1:0]            slot_id   [TABLE_DEPTH];
    logic [ID_W-1:0]            fresh_id;
    logic [CFG_W-1:0]           keep_frames;
    logic [CFG_W-1:0]           radius;

    track_result_t pending_tracks[$];

    initial begin
        fail_count  = 0;
        results_due = 0;
    end

    // Sum is formed one bit wider so that it never wraps.
    function automatic logic still_fresh(input int s, input logic [FRAME_W-1:0] frame);
        age_t reach;
        reach = age_t'(slot_seen[s]) + age_t'(keep_frames);
        return reach >= age_t'(frame);
    endfunction

    function automatic track_result_t purge_aged(input logic [FRAME_W-1:0] frame);
        track_result_t res;
        int            kept;
        int            dropped;
        res     = '0;
        kept    = 0;
        dropped = 0;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (slot_live[s]) begin
                if (!still_fresh(s, frame)) begin
                    dropped++;
                end else begin
                    slot_cx[kept]   = slot_cx[s];
                    slot_cy[kept]   = slot_cy[s];
                    slot_seen[kept] = slot_seen[s];
                    slot_id[kept]   = slot_id[s];
                    slot_live[kept] = 1'b1;
                    kept++;
                end
            end
        end
        for (int s = kept; s < TABLE_DEPTH; s++) slot_live[s] = 1'b0;
        res.removed_count = REMOVED_W'(dropped);
        return res;
    endfunction

    function automatic track_result_t associate_box(
        input logic signed [COORD_W-1:0] left,
        input logic signed [COORD_W-1:0] top,
        input logic signed [COORD_W-1:0] right,
        input logic signed [COORD_W-1:0] bottom,
        input logic [FRAME_W-1:0]        frame
    );
        track_result_t res;
        int            cx;
        int            cy;
        int            lim;
        int            dx;
        int            dy;
        int            hit;
        int            free_slot;
        int            next_id;
        res       = '0;
        cx        = int'(left) + int'(right);
        cy        = int'(top) + int'(bottom);
        lim       = 2 * int'(radius);
        hit       = -1;
        free_slot = -1;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            if (!slot_live[s]) begin
                if (free_slot < 0) free_slot = s;
            end else if (hit < 0) begin
                dx = int'(slot_cx[s]) - cx;
                dy = int'(slot_cy[s]) - cy;
                if (dx < lim && dx > -lim && dy < lim && dy > -lim && still_fresh(s, frame))
                    hit = s;
            end
        end
        if (hit >= 0) begin
            slot_cx[hit]   = CENTRE_W'(cx);
            slot_cy[hit]   = CENTRE_W'(cy);
            slot_seen[hit] = frame;
            res.track_id   = slot_id[hit];
        end else begin
            res.is_new   = 1'b1;
            res.track_id = fresh_id;
            next_id      = int'(fresh_id) + 1;
            fresh_id     = (next_id >= ID_MODULUS) ? '0 : ID_W'(next_id);
            if (free_slot >= 0) begin
                slot_live[free_slot] = 1'b1;
                slot_cx[free_slot]   = CENTRE_W'(cx);
                slot_cy[free_slot]   = CENTRE_W'(cy);
                slot_seen[free_slot] = frame;
                slot_id[free_slot]   = res.track_id;
            end else begin
                res.table_full = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        track_result_t want;
        track_result_t predicted;
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_DEPTH; s++) slot_live[s] = 1'b0;
            fresh_id    = '0;
            keep_frames = CFG_W'(10);
            radius      = CFG_W'(10);
            pending_tracks.delete();
        end else begin
            if (o_strobe) begin
                if (pending_tracks.size() == 0) begin
                    $error("track_id: expected no beat, got %0d", o_track_id);
                    fail_count++;
                end else begin
                    want = pending_tracks.pop_front();
                    if (o_track_id !== want.track_id) begin
                        $error("track_id: expected %0d, got %0d", want.track_id, o_track_id);
                        fail_count++;
                    end
                    if (o_is_new !== want.is_new) begin
                        $error("is_new: expected %0d, got %0d", want.is_new, o_is_new);
                        fail_count++;
                    end
                    if (o_table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, o_table_full);
                        fail_count++;
                    end
                    if (o_removed_count !== want.removed_count) begin
                        $error("removed_count: expected %0d, got %0d",
                               want.removed_count, o_removed_count);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_KEEP_LIMIT) keep_frames = i_cfg_data;
                else radius = i_cfg_data;
            end
            if (start && !busy) begin
                if (i_op == OP_PURGE)
                    predicted = purge_aged(i_frame_number);
                else
                    predicted = associate_box(i_box_left, i_box_top, i_box_right,
                                              i_box_bottom, i_frame_number);
                pending_tracks = {pending_tracks, predicted};
            end
        end
        results_due = pending_tracks.size();
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ptt_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int TARGETS     = 12;

    localparam logic signed [COORD_W-1:0] XY_MIN  = COORD_W'(-4096);
    localparam logic signed [COORD_W-1:0] XY_MAX  = COORD_W'(4095);
    localparam logic signed [COORD_W-1:0] XY_ZERO = '0;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic                       i_op         = OP_BOX;
    logic signed [COORD_W-1:0]  i_box_left   = '0;
    logic signed [COORD_W-1:0]  i_box_top    = '0;
    logic signed [COORD_W-1:0]  i_box_right  = '0;
    logic signed [COORD_W-1:0]  i_box_bottom = '0;
    logic [FRAME_W-1:0]         i_frame_number = '0;
    logic                       o_strobe;
    logic [ID_W-1:0]            o_track_id;
    logic                       o_is_new;
    logic                       o_table_full;
    logic [REMOVED_W-1:0]       o_removed_count;
    logic                       i_cfg_valid  = 1'b0;
    logic                       o_cfg_ready;
    logic                       i_cfg_index  = CFG_KEEP_LIMIT;
    logic [CFG_W-1:0]           i_cfg_data   = '0;

    int                 fail_count;
    int                 results_due;
    int                 cycle_count = 0;
    int                 keep_now    = 10;
    int                 radius_now  = 10;
    logic [FRAME_W-1:0] frame       = '0;
    int                 tgt_x [TARGETS];
    int                 tgt_y [TARGETS];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    proximity_track_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_box_left      (i_box_left),
        .i_box_top       (i_box_top),
        .i_box_right     (i_box_right),
        .i_box_bottom    (i_box_bottom),
        .i_frame_number  (i_frame_number),
        .o_strobe        (o_strobe),
        .o_track_id      (o_track_id),
        .o_is_new        (o_is_new),
        .o_table_full    (o_table_full),
        .o_removed_count (o_removed_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ptt_checker track_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_box_left      (i_box_left),
        .i_box_top       (i_box_top),
        .i_box_right     (i_box_right),
        .i_box_bottom    (i_box_bottom),
        .i_frame_number  (i_frame_number),
        .o_strobe        (o_strobe),
        .o_track_id      (o_track_id),
        .o_is_new        (o_is_new),
        .o_table_full    (o_table_full),
        .o_removed_count (o_removed_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .fail_count      (fail_count),
        .results_due     (results_due)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(
        input logic                      op,
        input logic signed [COORD_W-1:0] left,
        input logic signed [COORD_W-1:0] top,
        input logic signed [COORD_W-1:0] right,
        input logic signed [COORD_W-1:0] bottom,
        input logic [FRAME_W-1:0]        frame_no
    );
        start          <= 1'b1;
        i_op           <= op;
        i_box_left     <= left;
        i_box_top      <= top;
        i_box_right    <= right;
        i_box_bottom   <= bottom;
        i_frame_number <= frame_no;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold the sender until every pending beat has come back.
    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (results_due != 0);
        @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input int keep, input int radius);
        drain();
        cfg_beat(CFG_KEEP_LIMIT, keep);
        cfg_beat(CFG_MATCH_RADIUS, radius);
        i_cfg_valid <= 1'b0;
        keep_now   = keep;
        radius_now = radius;
    endtask

    task automatic run_phase(input int keep, input int radius, input int pct, input int count);
        int                        sel;
        int                        step;
        int                        k;
        int                        hw;
        int                        hh;
        logic signed [COORD_W-1:0] l;
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] r;
        logic signed [COORD_W-1:0] b;
        set_config(keep, radius);
        frame = $urandom;
        for (int n = 0; n < count; n++) begin
            step = $urandom_range(0, 99);
            if (step >= 70 && step < 88) frame = frame + 1;
            else if (step >= 88 && step < 95) frame = frame + $urandom_range(2, keep_now + 2);
            else if (step >= 95 && step < 97) frame = frame + keep_now + $urandom_range(1, 50);
            else if (step >= 97 && step < 99) frame = frame - $urandom_range(1, 30);
            else if (step == 99) frame = $urandom;
            k = $urandom_range(0, TARGETS - 1);
            if ($urandom_range(0, 99) < 3) begin
                tgt_x[k] = int'($urandom_range(0, 6800)) - 3400;
                tgt_y[k] = int'($urandom_range(0, 6800)) - 3400;
            end
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                send_item((sel < 7) ? OP_PURGE : OP_BOX, COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), COORD_W'($urandom), frame);
            end else begin
                hw = $urandom_range(0, 300);
                hh = $urandom_range(0, 300);
                l  = COORD_W'(tgt_x[k] - hw + int'($urandom_range(0, 2 * radius_now + 2))
                              - (radius_now + 1));
                r  = COORD_W'(tgt_x[k] + hw + int'($urandom_range(0, 2 * radius_now + 2))
                              - (radius_now + 1));
                t  = COORD_W'(tgt_y[k] - hh + int'($urandom_range(0, 2 * radius_now + 2))
                              - (radius_now + 1));
                b  = COORD_W'(tgt_y[k] + hh + int'($urandom_range(0, 2 * radius_now + 2))
                              - (radius_now + 1));
                send_item(OP_BOX, l, t, r, b, frame);
            end
            if ($urandom_range(0, 199) == 0) drain();
            else idle_gap(pct);
        end
    endtask

    initial begin
        for (int k = 0; k < TARGETS; k++) begin
            tgt_x[k] = int'($urandom_range(0, 6800)) - 3400;
            tgt_y[k] = int'($urandom_range(0, 6800)) - 3400;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, exclusive radius edge, earliest entry wins
        send_item(OP_BOX, XY_MIN, XY_MIN, XY_MIN, XY_MIN, 0);
        send_item(OP_BOX, XY_MIN, XY_MIN, XY_MIN, XY_MIN, 0);
        send_item(OP_BOX, XY_MAX, XY_MAX, XY_MAX, XY_MAX, 0);
        send_item(OP_BOX, XY_MIN, XY_MIN, COORD_W'(-4076), XY_MIN, 0);
        send_item(OP_BOX, XY_MIN, XY_MIN, COORD_W'(-4077), XY_MIN, 0);
        send_item(OP_PURGE, XY_ZERO, XY_ZERO, XY_ZERO, XY_ZERO, 11);
        // fill the table, then overflow it
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_item(OP_BOX, COORD_W'(-4000 + 400 * i), COORD_W'(100),
                      COORD_W'(-4000 + 400 * i), COORD_W'(100), 11);
        send_item(OP_PURGE, XY_MAX, XY_MIN, XY_MAX, XY_MIN, 32'hFFFF_FFFF);
        // age sum must not wrap past the top frame
        send_item(OP_BOX, XY_ZERO, XY_ZERO, XY_ZERO, XY_ZERO, 32'hFFFF_FFFF);
        send_item(OP_BOX, COORD_W'(1), COORD_W'(1), COORD_W'(1), COORD_W'(1), 5);
        set_config(10, 0);
        send_item(OP_BOX, XY_ZERO, XY_ZERO, XY_ZERO, XY_ZERO, 5);
        send_item(OP_BOX, XY_ZERO, XY_ZERO, XY_ZERO, XY_ZERO, 5);

        run_phase(10, 10, 0, 200);
        run_phase(0, 1, 47, 200);
        run_phase(255, 255, 11, 200);
        run_phase(0, 0, 0, 400);
        run_phase(3, 4, 47, 200);
        run_phase(255, 1, 11, 150);
        run_phase(1, 40, 47, 200);
        run_phase(20, 12, 0, 150);

        drain();
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
design/ptt_pkg.sv
design/ptt_ram.sv
design/ptt_front.sv
design/ptt_back.sv
design/proximity_track_table.sv
bench/ptt_checker.sv
bench/tb_top.sv
